FILE: design/ipv6_binary_trie_lpm_top_defines.svh
// assertion macros for the ipv6 trie lookup block
`ifndef IPV6_BINARY_TRIE_LPM_TOP_DEFINES_SVH
`define IPV6_BINARY_TRIE_LPM_TOP_DEFINES_SVH
// property holds on every clock unless in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: design/iptrie_pkg.sv
// shared types and constants for the ipv6 trie lookup block
`timescale 1ns / 1ps
package iptrie_pkg;
  localparam int NodesDefault = 4096;
  localparam int AddrBits = 128;
  localparam int HalfBits = 64;
  localparam int LenW = 8;
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic           mode;
    logic [63:0]    addr_hi;
    logic [63:0]    addr_lo;
    logic [LenW-1:0] len;
  } job_t;

  typedef struct packed {
    logic           found;
    logic           status;
    logic [LenW-1:0] match_len;
    logic [63:0]    match_hi;
    logic [63:0]    match_lo;
  } res_t;
endpackage

FILE: design/iptrie_front.sv
// front end: accepts items, clamps the prefix length, queues jobs
`timescale 1ns / 1ps
module iptrie_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [136:0]       in_data,
  output logic               job_valid,
  input  logic               job_ready,
  output iptrie_pkg::job_t   job
);
  import iptrie_pkg::*;
  // two-entry queue
  job_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  job_t inj;
  logic push, pop;

  always_comb begin
    inj.mode = in_data[0];
    inj.addr_hi = in_data[64:1];
    inj.addr_lo = in_data[128:65];
    inj.len = (in_data[136:129] > LenW'(AddrBits)) ? LenW'(AddrBits) : in_data[136:129];
  end

  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign job_valid = (cnt != 2'd0);
  assign pop = job_valid && job_ready;
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= inj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: design/iptrie_back.sv
// back end: walks the trie one level at a time in the node memories
`timescale 1ns / 1ps
module iptrie_back #(
  parameter int NODES = iptrie_pkg::NodesDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  iptrie_pkg::job_t job,
  output logic             res_valid,
  input  logic             res_ready,
  output iptrie_pkg::res_t res
);
  import iptrie_pkg::*;
  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // node store: child pair and mark share one word, prefix in another
  logic [2*NW:0] link_mem [NODES];
  logic [LenW+127:0] pfx_mem [NODES];
  logic [2*NW:0] link_rd;
  logic [LenW+127:0] pfx_rd;
  logic [NW-1:0] rd_addr;
  logic link_we, pfx_we;
  logic [NW-1:0] link_wa, pfx_wa;
  logic [2*NW:0] link_wd;

  logic [2:0] state;
  job_t cur;
  logic [NW-1:0] node;
  logic [LenW-1:0] depth;
  logic [CW-1:0] next_free;
  logic [NW-1:0] clr;
  logic walked;
  res_t acc;
  res_t out_r;
  logic out_v;

  // parent hook held in a small register and written during the following read state
  logic hook;
  logic [NW-1:0] hook_node, hook_child;
  logic hook_bit;
  logic [2*NW:0] hook_word;

  logic bit_sel;
  logic [NW-1:0] child;
  logic [6:0] bidx;

  assign bidx = 7'(AddrBits - 1) - depth[6:0];
  assign bit_sel = bidx[6] ? cur.addr_hi[bidx[5:0]] : cur.addr_lo[bidx[5:0]];
  assign child = bit_sel ? link_rd[2*NW:NW+1] : link_rd[NW:1];

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd <= link_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (pfx_we) pfx_mem[pfx_wa] <= {cur.len, cur.addr_hi, cur.addr_lo};
    pfx_rd <= pfx_mem[rd_addr];
  end

  assign job_ready = (state == S_IDLE);
  assign res_valid = out_v;
  assign res = out_r;

  always_comb begin
    rd_addr = node;
    link_we = 1'b0;
    link_wa = node;
    link_wd = link_rd;
    pfx_we = 1'b0;
    pfx_wa = node;
    unique case (state)
      S_CLEAR: begin
        link_we = 1'b1;
        link_wa = clr;
        link_wd = '0;
      end
      S_READ: begin
        if (hook) begin
          // parent link update while the walk holds in the read state
          link_we = 1'b1;
          link_wa = hook_node;
          link_wd = hook_bit ? {hook_child, hook_word[NW:0]}
                             : {hook_word[2*NW:NW+1], hook_child, hook_word[0]};
        end
      end
      S_STEP: begin
        if (cur.mode == MODE_INSERT && depth < cur.len && child == '0
            && next_free < CW'(NODES)) begin
          // new child: fresh node, then hook into parent
          link_we = 1'b1;
          link_wa = NW'(next_free);
          link_wd = '0;
        end
      end
      S_MARK: begin
        link_we = 1'b1;
        link_wa = node;
        link_wd = {link_rd[2*NW:1], 1'b1};
        pfx_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      next_free <= CW'(1);
      out_v <= 1'b0;
      hook <= 1'b0;
    end else begin
      hook <= 1'b0;
      if (out_v && res_ready) out_v <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + NW'(1);
          if (clr == NW'(NODES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            node <= '0;
            depth <= '0;
            walked <= 1'b0;
            acc <= '0;
            state <= S_READ;
          end
        end
        S_READ: state <= hook ? S_READ : S_STEP;
        S_STEP: begin
          if (walked && cur.mode == MODE_LOOKUP && link_rd[0]) begin
            acc.found <= 1'b1;
            acc.match_len <= pfx_rd[LenW+127:128];
            acc.match_hi <= pfx_rd[127:64];
            acc.match_lo <= pfx_rd[63:0];
          end
          if (cur.mode == MODE_LOOKUP) begin
            if (depth == LenW'(AddrBits) || child == '0) state <= S_DONE;
            else begin
              node <= child;
              depth <= depth + LenW'(1);
              walked <= 1'b1;
              state <= S_READ;
            end
          end else if (depth == cur.len) begin
            state <= S_MARK;
          end else if (child != '0) begin
            node <= child;
            depth <= depth + LenW'(1);
            state <= S_READ;
          end else if (next_free >= CW'(NODES)) begin
            acc.status <= 1'b1;
            state <= S_DONE;
          end else begin
            hook <= 1'b1;
            hook_node <= node;
            hook_child <= NW'(next_free);
            hook_bit <= bit_sel;
            hook_word <= link_rd;
            next_free <= next_free + CW'(1);
            node <= NW'(next_free);
            depth <= depth + LenW'(1);
            state <= S_READ;
          end
        end
        S_MARK: state <= S_DONE;
        S_DONE: begin
          // result register frees the walk for the next item
          if (!out_v) begin
            out_r <= acc;
            out_v <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/ipv6_binary_trie_lpm_top.sv
// top level of the ipv6 binary trie longest prefix match block
`timescale 1ns / 1ps
// binary trie for 128-bit ipv6 longest prefix match. s_axis carries one insert
// (mode 0) or lookup (mode 1) per transfer; m_axis returns one result for each.
// the front queues up to two items while the back walks the trie. the back
// handles each trie level with a node memory read, then a decide step; an
// insert also holds in the read state for each node it allocates, while the
// parent link to that node is written. a result register lets the back start
// the next item while a result waits; the back then holds in its done state.
// after reset a clearing pass sweeps every word of the link memory before
// the first item is taken. a full node store makes an insert report status 1.
module ipv6_binary_trie_lpm_top #(
  parameter int NODES = iptrie_pkg::NodesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // mode, addr_hi, addr_lo, prefix_len
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata   // found, status, match_len, match_hi, match_lo
);
  import iptrie_pkg::*;
  logic job_valid, job_ready;
  job_t job;
  res_t res;

  iptrie_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata[136:0]),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  iptrie_back #(.NODES(NODES)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  // pack result, first field lowest
  assign m_axis_tdata = {6'd0, res.match_lo, res.match_hi, res.match_len,
                         res.status, res.found};
endmodule

FILE: design/iptrie_checker.sv
// port checker for the ipv6 trie block and its bind
`timescale 1ns / 1ps
`include "ipv6_binary_trie_lpm_top_defines.svh"
module iptrie_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [143:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata
);
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `ASSERT_CLK(a_found_ok, m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1], "found with full")
  `ASSERT_CLK(a_miss_zero, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[9:2] == 8'd0, "miss len")
  `ASSERT_ALWAYS(a_rst_idle, $past(rst) |-> !m_axis_tvalid, "valid after reset")
endmodule

bind ipv6_binary_trie_lpm_top iptrie_checker u_chk (.*);

FILE: bench/tb_ipv6_binary_trie_lpm_top.sv
// self-checking testbench for the ipv6 binary trie longest prefix match block
`timescale 1ns / 1ps

// keeps a private copy of the trie and the queue of results still to come
class trie_scoreboard;
  localparam int NodeCount = iptrie_pkg::NodesDefault;
  localparam int AddrW = iptrie_pkg::AddrBits;

  bit [11:0] lchild [NodeCount];
  bit [11:0] rchild [NodeCount];
  bit        marked [NodeCount];
  bit [63:0] pfx_hi [NodeCount];
  bit [63:0] pfx_lo [NodeCount];
  bit [7:0]  pfx_len [NodeCount];
  int        next_free;
  iptrie_pkg::res_t pending_results [$];
  int        errors;

  function new();
    for (int i = 0; i < NodeCount; i++) begin
      lchild[i] = '0;
      rchild[i] = '0;
      marked[i] = 1'b0;
      pfx_hi[i] = '0;
      pfx_lo[i] = '0;
      pfx_len[i] = '0;
    end
    next_free = 1;
    errors = 0;
  endfunction

  // walk bit for depth d: bit 127 first, the upper half holds bits 127..64
  function bit walk_bit(bit [63:0] hi, bit [63:0] lo, int d);
    bit [127:0] full;
    full = {hi, lo};
    return full[AddrW - 1 - d];
  endfunction

  function bit insert_prefix(bit [63:0] hi, bit [63:0] lo, bit [7:0] len_in);
    int n;
    int c;
    int len;
    bit b;
    len = (len_in > AddrW) ? AddrW : len_in;
    n = 0;
    for (int d = 0; d < len; d++) begin
      b = walk_bit(hi, lo, d);
      c = b ? rchild[n] : lchild[n];
      if (c == 0) begin
        if (next_free >= NodeCount) return 1'b1;
        c = next_free;
        next_free++;
        lchild[c] = '0;
        rchild[c] = '0;
        marked[c] = 1'b0;
        if (b) rchild[n] = 12'(c);
        else lchild[n] = 12'(c);
      end
      n = c;
    end
    pfx_hi[n] = hi;
    pfx_lo[n] = lo;
    pfx_len[n] = 8'(len);
    marked[n] = 1'b1;
    return 1'b0;
  endfunction

  function iptrie_pkg::res_t longest_match(bit [63:0] hi, bit [63:0] lo);
    iptrie_pkg::res_t r;
    int n;
    int c;
    r = '0;
    n = 0;
    for (int d = 0; d < AddrW; d++) begin
      c = walk_bit(hi, lo, d) ? rchild[n] : lchild[n];
      if (c == 0) break;
      n = c;
      if (marked[n]) begin
        r.found = 1'b1;
        r.match_len = pfx_len[n];
        r.match_hi = pfx_hi[n];
        r.match_lo = pfx_lo[n];
      end
    end
    return r;
  endfunction

  // called for every accepted input transfer
  function void note_request(bit mode, bit [63:0] hi, bit [63:0] lo, bit [7:0] len);
    iptrie_pkg::res_t r;
    r = '0;
    if (mode == iptrie_pkg::MODE_INSERT) r.status = insert_prefix(hi, lo, len);
    else r = longest_match(hi, lo);
    pending_results.push_back(r);
  endfunction

  // called for every accepted output transfer
  function void check_result(bit [143:0] data);
    iptrie_pkg::res_t exp_r;
    iptrie_pkg::res_t got;
    got.found = data[0];
    got.status = data[1];
    got.match_len = data[9:2];
    got.match_hi = data[73:10];
    got.match_lo = data[137:74];
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $realtime, data);
      errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    if (got.found !== exp_r.found)
      $display("%0t: found expected %0d actual %0d", $realtime, exp_r.found, got.found);
    if (got.status !== exp_r.status)
      $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, got.status);
    if (got.match_len !== exp_r.match_len)
      $display("%0t: match_len expected %0d actual %0d", $realtime,
               exp_r.match_len, got.match_len);
    if (got.match_hi !== exp_r.match_hi)
      $display("%0t: match_hi expected %h actual %h", $realtime, exp_r.match_hi, got.match_hi);
    if (got.match_lo !== exp_r.match_lo)
      $display("%0t: match_lo expected %h actual %h", $realtime, exp_r.match_lo, got.match_lo);
    if (got !== exp_r) errors++;
    if (data[143:138] !== '0) begin
      $display("%0t: pad bits expected 0 actual %h", $realtime, data[143:138]);
      errors++;
    end
  endfunction
endclass

module tb_ipv6_binary_trie_lpm_top;
  import iptrie_pkg::*;

  localparam int RandomItems = 1200;
  localparam int PhaseItems = RandomItems / 4;
  localparam int HoldCycles = 3000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;

  trie_scoreboard sb;

  // idle percentages of the current traffic phase
  int send_idle_pct;
  int recv_idle_pct;
  int sent_count;
  int hold_left;
  bit hold_done;

  // stored prefixes, used to aim lookups and inserts at populated branches
  bit [127:0] known_pfx [$];
  int         known_len [$];

  ipv6_binary_trie_lpm_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && sent_count == 60) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // output monitor: every result transfer goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // one input transfer; data fields packed from bit 0: mode, hi, lo, length
  task automatic send_request(bit mode, bit [63:0] hi, bit [63:0] lo, bit [7:0] len);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, len, lo, hi, mode};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(mode, hi, lo, len);
    sent_count++;
    if (mode == MODE_INSERT) begin
      known_pfx.push_back({hi, lo});
      known_len.push_back(len > AddrBits ? AddrBits : len);
    end
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic bit [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // keep the top len bits of a stored prefix, randomize the rest
  function automatic bit [127:0] aim_at(bit [127:0] pfx, int len);
    bit [127:0] mask;
    mask = (len == 0) ? '0 : ({128{1'b1}} << (AddrBits - len));
    return (pfx & mask) | (rand128() & ~mask);
  endfunction

  task automatic random_item();
    bit [127:0] a;
    bit [7:0]   len;
    int         pick;
    int         k;
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      pick = $urandom_range(99, 0);
      if (pick < 55) len = 8'($urandom_range(32, 0));
      else if (pick < 80) len = 8'($urandom_range(128, 33));
      else if (pick < 92) len = 8'(AddrBits);
      else len = 8'($urandom_range(255, 129));
      a = rand128();
      // often grow an existing branch deeper
      if (known_pfx.size() > 0 && $urandom_range(1, 0)) begin
        k = $urandom_range(known_pfx.size() - 1, 0);
        a = aim_at(known_pfx[k], known_len[k]);
      end
      send_request(MODE_INSERT, a[127:64], a[63:0], len);
    end else begin
      a = rand128();
      if (known_pfx.size() > 0 && $urandom_range(99, 0) < 75) begin
        k = $urandom_range(known_pfx.size() - 1, 0);
        a = aim_at(known_pfx[k], known_len[k]);
      end
      // lookup ignores the length field, so it carries noise
      send_request(MODE_LOOKUP, a[127:64], a[63:0], 8'($urandom_range(255, 0)));
    end
  endtask

  initial begin
    int waited;
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty trie, root prefix, half boundary, extremes, long lengths
    send_request(MODE_LOOKUP, '1, '1, 8'd0);
    send_request(MODE_INSERT, '1, '1, 8'd0);
    send_request(MODE_LOOKUP, '1, '1, 8'd0);
    send_request(MODE_INSERT, 64'h0, 64'h0, 8'd1);
    send_request(MODE_INSERT, 64'h8000_0000_0000_0000, 64'h0, 8'd1);
    send_request(MODE_LOOKUP, 64'h0, 64'h0, 8'd255);
    send_request(MODE_LOOKUP, '1, 64'h0, 8'd0);
    send_request(MODE_INSERT, 64'h2001_0db8_0000_0001, 64'h0, 8'd64);
    send_request(MODE_INSERT, 64'h2001_0db8_0000_0001, 64'h8000_0000_0000_0000, 8'd65);
    send_request(MODE_LOOKUP, 64'h2001_0db8_0000_0001, 64'h8000_0000_0000_1234, 8'd0);
    send_request(MODE_LOOKUP, 64'h2001_0db8_0000_0001, 64'h7fff_0000_0000_0000, 8'd0);
    send_request(MODE_INSERT, '1, '1, 8'd128);
    send_request(MODE_LOOKUP, '1, '1, 8'd0);
    send_request(MODE_LOOKUP, '1, 64'hffff_ffff_ffff_fffe, 8'd0);
    send_request(MODE_INSERT, 64'h0, 64'h0, 8'd200);
    send_request(MODE_INSERT, 64'h0, 64'h1, 8'd255);
    send_request(MODE_LOOKUP, 64'h0, 64'h1, 8'd0);
    send_request(MODE_LOOKUP, 64'h0, 64'h0, 8'd0);
    // repeated prefix with different host bits overwrites the stored value
    send_request(MODE_INSERT, 64'h2001_0db8_0000_0001, 64'h0000_0000_0000_abcd, 8'd64);
    send_request(MODE_LOOKUP, 64'h2001_0db8_0000_0001, 64'h0000_0000_0000_0000, 8'd0);
    send_request(MODE_INSERT, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa, 8'd127);
    send_request(MODE_LOOKUP, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaab, 8'd0);

    // random traffic in four idling phases; the store fills up along the way
    for (int i = 0; i < RandomItems; i++) begin
      case (i / PhaseItems)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 63;
        end
        default: begin
          send_idle_pct = 33;
          recv_idle_pct = 33;
        end
      endcase
      random_item();
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (sb.pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run watchdog
  initial begin
    #(60_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+design
design/iptrie_pkg.sv
design/iptrie_front.sv
design/iptrie_back.sv
design/ipv6_binary_trie_lpm_top.sv
design/iptrie_checker.sv
bench/tb_ipv6_binary_trie_lpm_top.sv
